// File: rtl/core/amsu_pkg.sv
// Shared constants, codes and word types of the adjacency matrix store.
`default_nettype none

package amsu_pkg;

   // Store geometry
   localparam int MAX_VERTICES   = 256;
   localparam int WEIGHT_BITS    = 32;
   localparam int VTX_BITS       = 8;
   localparam int CNT_BITS       = VTX_BITS + 1;
   localparam int DEG_BITS       = VTX_BITS + 1;
   localparam int PAIR_BITS      = 2 * VTX_BITS;

   // Row scan slicing
   localparam int CHUNK_BITS     = 32;
   localparam int NUM_CHUNKS     = MAX_VERTICES / CHUNK_BITS;
   localparam int CHUNK_IDX_BITS = $clog2(NUM_CHUNKS);
   localparam int CHUNK_POS_BITS = $clog2(CHUNK_BITS);
   localparam int CHUNK_CNT_BITS = CHUNK_POS_BITS + 1;

   // Action codes
   localparam logic [2:0] ACT_ADD_VERTEX  = 3'd0;
   localparam logic [2:0] ACT_ADD_EDGE    = 3'd1;
   localparam logic [2:0] ACT_REMOVE_EDGE = 3'd2;
   localparam logic [2:0] ACT_DEGREE      = 3'd3;
   localparam logic [2:0] ACT_NEXT_ADJ    = 3'd4;
   localparam logic [2:0] ACT_EDGE_WEIGHT = 3'd5;

   // Status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [2:0]             action;
      logic [VTX_BITS-1:0]    src_vertex;
      logic [VTX_BITS-1:0]    dst_vertex;
      logic [VTX_BITS-1:0]    start_vertex;
      logic [WEIGHT_BITS-1:0] weight_in;
   } req_word_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [VTX_BITS-1:0]    vertex_out;
      logic                   found;
      logic [DEG_BITS-1:0]    degree_out;
      logic                   edge_present;
      logic [WEIGHT_BITS-1:0] weight_out;
   } rsp_word_type;

   // Control from the sequencer to the row scanner
   typedef struct packed {
      logic                start;
      logic                find_next;
      logic [VTX_BITS-1:0] first;
      logic [CNT_BITS-1:0] count;
   } scan_ctrl_type;

   // Result from the row scanner
   typedef struct packed {
      logic                done;
      logic                found;
      logic [VTX_BITS-1:0] index;
      logic [DEG_BITS-1:0] degree;
   } scan_result_type;

endpackage

`default_nettype wire

// File: rtl/core/adjacency_matrix_store_unit.sv
// Top level of the weighted directed adjacency matrix store.
//
// Usage: drive a request word on req_word and raise start; the word is taken
// at a clock edge where start is high and busy is low. Exactly one response
// word follows, shown on rsp_word for one cycle with rsp_strobe high; the
// receiver has no way to hold it off and must take it then.
// Add vertex, add edge, remove edge, edge weight and any request that ends
// with a bad-vertex status answer straight from the execute state.
// Degree and next adjacent go on to a row scan: the row is scanned
// 32 bits per cycle over 8 chunks; next adjacent stops at the first chunk
// with a hit, degree scans them all. The row and weight memories have
// registered reads, started at accept; a new request can be accepted in
// the cycle its predecessor's strobe is high.
// Reset clears the vertex count and the per-row valid bits, so every row
// reads as empty; no memory clearing pass is needed. Weight words are only
// read behind a set presence bit.
`default_nettype none

module adjacency_matrix_store_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire amsu_pkg::req_word_type req_word,
   output logic                        busy,
   output logic                        rsp_strobe,
   output amsu_pkg::rsp_word_type      rsp_word
);

   import amsu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;
   req_word_type            req_ff, req_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type            rsp_ff, rsp_in;

   logic                    accept;
   logic [MAX_VERTICES-1:0] row_rd_data;
   logic [MAX_VERTICES-1:0] row_cur;
   logic [MAX_VERTICES-1:0] dst_mask;
   logic                    row_wr_en;
   logic [MAX_VERTICES-1:0] row_wr_data;
   logic                    wt_wr_en;
   logic [WEIGHT_BITS-1:0]  wt_rd_data;
   logic                    u_ok, v_ok, first_ok;
   logic                    present;
   scan_ctrl_type           scan_ctrl;
   scan_result_type         scan_result;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Row presence memory
   amsu_ram #(
      .WIDTH(MAX_VERTICES),
      .DEPTH(MAX_VERTICES)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (row_wr_en),
      .wr_addr(req_ff.src_vertex),
      .wr_data(row_wr_data),
      .rd_en  (accept),
      .rd_addr(req_word.src_vertex),
      .rd_data(row_rd_data)
   );

   // Edge weight memory, addressed by the (src, dst) pair
   amsu_ram #(
      .WIDTH(WEIGHT_BITS),
      .DEPTH(MAX_VERTICES * MAX_VERTICES)
   ) u_weight_ram (
      .clock  (clock),
      .wr_en  (wt_wr_en),
      .wr_addr({req_ff.src_vertex, req_ff.dst_vertex}),
      .wr_data(req_ff.weight_in),
      .rd_en  (accept),
      .rd_addr({req_word.src_vertex, req_word.dst_vertex}),
      .rd_data(wt_rd_data)
   );

   amsu_row_scan u_row_scan (
      .clock (clock),
      .reset (reset),
      .ctrl  (scan_ctrl),
      .row   (row_cur),
      .result(scan_result)
   );

   // Range checks and the current row; a row never written reads empty
   assign u_ok     = ({1'b0, req_ff.src_vertex} < count_ff);
   assign v_ok     = ({1'b0, req_ff.dst_vertex} < count_ff);
   assign first_ok = ({1'b0, req_ff.start_vertex} < count_ff);
   assign row_cur  = row_valid_ff[req_ff.src_vertex] ? row_rd_data : '0;
   assign dst_mask = {{(MAX_VERTICES - 1){1'b0}}, 1'b1} << req_ff.dst_vertex;
   assign present  = row_cur[req_ff.dst_vertex];

   // Sequencer: accept, execute against read data, optional row scan
   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      row_valid_in        = row_valid_ff;
      req_in              = req_ff;
      rsp_strobe_in       = 1'b0;
      rsp_in              = rsp_ff;
      row_wr_en           = 1'b0;
      row_wr_data         = row_cur;
      wt_wr_en            = 1'b0;
      scan_ctrl.start     = 1'b0;
      scan_ctrl.find_next = (req_ff.action == ACT_NEXT_ADJ);
      scan_ctrl.first     = req_ff.start_vertex;
      scan_ctrl.count     = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_word;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in        = '0;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            case (req_ff.action)
               ACT_ADD_VERTEX: begin
                  if (count_ff == CNT_BITS'(MAX_VERTICES)) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     rsp_in.vertex_out = count_ff[VTX_BITS-1:0];
                     count_in          = count_ff + 1'b1;
                  end
               end
               ACT_ADD_EDGE: begin
                  if (!u_ok || !v_ok) begin
                     rsp_in.status = STATUS_INVALID;
                  end else begin
                     row_wr_en   = 1'b1;
                     row_wr_data = row_cur | dst_mask;
                     wt_wr_en    = 1'b1;
                  end
               end
               ACT_REMOVE_EDGE: begin
                  if (!u_ok || !v_ok) begin
                     rsp_in.status = STATUS_INVALID;
                  end else begin
                     row_wr_en   = 1'b1;
                     row_wr_data = row_cur & ~dst_mask;
                  end
               end
               ACT_DEGREE: begin
                  if (!u_ok) begin
                     rsp_in.status = STATUS_INVALID;
                  end else begin
                     scan_ctrl.start = 1'b1;
                     rsp_strobe_in   = 1'b0;
                     state_in        = S_SCAN;
                  end
               end
               ACT_NEXT_ADJ: begin
                  if (!u_ok || !first_ok) begin
                     rsp_in.status = STATUS_INVALID;
                  end else begin
                     scan_ctrl.start = 1'b1;
                     rsp_strobe_in   = 1'b0;
                     state_in        = S_SCAN;
                  end
               end
               ACT_EDGE_WEIGHT: begin
                  if (!u_ok || !v_ok) begin
                     rsp_in.status = STATUS_INVALID;
                  end else if (present) begin
                     rsp_in.edge_present = 1'b1;
                     rsp_in.weight_out   = wt_rd_data;
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
            if (row_wr_en) begin
               row_valid_in[req_ff.src_vertex] = 1'b1;
            end
         end
         S_SCAN: begin
            if (scan_result.done) begin
               rsp_in            = '0;
               rsp_in.vertex_out = scan_result.index;
               rsp_in.found      = scan_result.found;
               rsp_in.degree_out = scan_result.degree;
               rsp_strobe_in     = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         row_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         row_valid_ff  <= row_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/amsu_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module amsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds data when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/amsu_row_scan.sv
// Row scanner: popcount or first-set search over one row, one chunk a cycle.
`default_nettype none

module amsu_row_scan (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire amsu_pkg::scan_ctrl_type              ctrl,
   input  wire logic [amsu_pkg::MAX_VERTICES-1:0]    row,
   output amsu_pkg::scan_result_type                 result
);

   import amsu_pkg::*;

   logic                      active_ff, active_in;
   logic                      find_next_ff, find_next_in;
   logic [VTX_BITS-1:0]       first_ff, first_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [MAX_VERTICES-1:0]   row_ff, row_in;
   logic [CHUNK_IDX_BITS-1:0] chunk_ff, chunk_in;
   logic [DEG_BITS-1:0]       degree_ff, degree_in;
   scan_result_type           result_ff, result_in;

   logic [CHUNK_BITS-1:0]     chunk_bits;
   logic [CHUNK_BITS-1:0]     masked;
   logic [CHUNK_CNT_BITS-1:0] pop;
   logic                      hit;
   logic [CHUNK_POS_BITS-1:0] pos;
   logic                      last_chunk;

   // Current chunk, masked to [first, count) when searching
   always_comb begin
      logic [VTX_BITS-1:0] idx;
      chunk_bits = row_ff[{chunk_ff, {CHUNK_POS_BITS{1'b0}}} +: CHUNK_BITS];
      for (int j = 0; j < CHUNK_BITS; j++) begin
         idx = {chunk_ff, CHUNK_POS_BITS'(j)};
         masked[j] = chunk_bits[j] &
                     (!find_next_ff ||
                      (({1'b0, idx} < count_ff) && (idx >= first_ff)));
      end
   end

   // Chunk popcount and lowest set bit
   always_comb begin
      pop = '0;
      hit = 1'b0;
      pos = '0;
      for (int j = 0; j < CHUNK_BITS; j++) begin
         pop = pop + CHUNK_CNT_BITS'(masked[j]);
      end
      for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
         if (masked[j]) begin
            hit = 1'b1;
            pos = CHUNK_POS_BITS'(j);
         end
      end
   end

   assign last_chunk = (chunk_ff == CHUNK_IDX_BITS'(NUM_CHUNKS - 1));

   // Scan sequencing
   always_comb begin
      active_in      = active_ff;
      find_next_in   = find_next_ff;
      first_in       = first_ff;
      count_in       = count_ff;
      row_in         = row_ff;
      chunk_in       = chunk_ff;
      degree_in      = degree_ff;
      result_in      = result_ff;
      result_in.done = 1'b0;
      if (ctrl.start) begin
         active_in    = 1'b1;
         find_next_in = ctrl.find_next;
         first_in     = ctrl.first;
         count_in     = ctrl.count;
         row_in       = row;
         chunk_in     = '0;
         degree_in    = '0;
      end else if (active_ff) begin
         if (find_next_ff && hit) begin
            active_in        = 1'b0;
            result_in.done   = 1'b1;
            result_in.found  = 1'b1;
            result_in.index  = {chunk_ff, pos};
            result_in.degree = '0;
         end else if (last_chunk) begin
            active_in        = 1'b0;
            result_in.done   = 1'b1;
            result_in.found  = 1'b0;
            result_in.index  = '0;
            result_in.degree = degree_ff + DEG_BITS'(pop);
         end else begin
            chunk_in  = chunk_ff + 1'b1;
            degree_in = degree_ff + DEG_BITS'(pop);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         result_ff <= '0;
      end else begin
         active_ff <= active_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      find_next_ff <= find_next_in;
      first_ff     <= first_in;
      count_ff     <= count_in;
      row_ff       <= row_in;
      chunk_ff     <= chunk_in;
      degree_ff    <= degree_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire
